// ===== hw/rtl/lspt_pkg.sv =====
// ----------------------------------------------------------------------------
// lspt_pkg: shared definitions for the line sensor position tracker
// Widths, register indexes, lost-side codes, controller states and the
// record that the channel scanner hands to the controller and the divider.
// ----------------------------------------------------------------------------
package lspt_pkg;

  localparam int MaxChannels = 8;
  localparam int ChanW       = $clog2(MaxChannels);
  localparam int CountW      = $clog2(MaxChannels + 1);
  localparam int Scale       = 1000;
  localparam int HalfScale   = Scale / 2;

  // Channel i of n sits at (2i - (n-1)) * Scale / 2. The scanner sums the
  // odd/even offset (2i - (n-1)) only; its magnitude is at most n*n/4.
  localparam int DigitMax    = (MaxChannels * MaxChannels) / 4;
  localparam int SumW        = $clog2(DigitMax + 1) + 1;
  localparam int MagW        = $clog2(DigitMax * HalfScale + 1);
  localparam int IterW       = $clog2(MagW + 1);

  localparam int PosW        = 16;
  localparam int TimeW       = 32;
  localparam int InW         = 40;
  localparam int OutW        = 144;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 32;

  localparam logic [CfgIdxW-1:0] REG_CHAN_NUM  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LOW_TRUE  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_PUBLISH   = 2'd2;

  localparam logic [1:0] SIDE_UNKNOWN = 2'd0;
  localparam logic [1:0] SIDE_LEFT    = 2'd1;
  localparam logic [1:0] SIDE_RIGHT   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_PUBLISH
  } state_t;

  typedef struct packed {
    logic [MaxChannels-1:0] raw;
    logic [MaxChannels-1:0] act;
    logic [CountW-1:0]      cnt;
    logic signed [SumW-1:0] sum;
  } scan_res_t;

endpackage

// ===== hw/rtl/line_sensor_position_tracker.sv =====
// ----------------------------------------------------------------------------
// line_sensor_position_tracker: line position from a row of sensor channels
// Gates monitor ticks by the publish period and publishes one sample per
// passing tick: masks, active count, mean line position and lost tracking.
// ----------------------------------------------------------------------------
// The block takes one request at a time. A tick that falls inside the publish
// period is consumed in the cycle it is taken and gives no sample. Any other
// tick is scanned and, when some channel sees the line, divided before it is
// published: the scanner looks at one channel per cycle, the divider is loaded
// once the scan ends and then produces one quotient bit per cycle over the
// 13-bit scaled sum. The finished sample sits in an output register, and the
// next request is taken while it waits there.
// Configuration writes are always taken; they should only be made while the
// block is idle. Ports m_tdata and s_tdata carry the fields packed from bit
// zero upwards as listed beside them.
module line_sensor_position_tracker (
  input  logic                            clk,
  input  logic                            rst,
  // s_tdata: raw_levels[7:0], now_ms[39:8]
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [lspt_pkg::InW-1:0]        s_tdata,
  // m_tdata: raw_bits[7:0], hit_bits[15:8], hit_count[19:16],
  // line_found[20], position[36:21], mean_pos[52:37],
  // miss_side[54:53], lost_ticks[86:55], memory_position[102:87],
  // flip_bits[110:103], sequence_number[142:111], zero[143]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [lspt_pkg::OutW-1:0]       m_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lspt_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [lspt_pkg::CfgDataW-1:0]   cfg_data
);
  import lspt_pkg::*;

  // Configuration registers.
  logic [CountW-1:0] chan_num;
  logic              low_true;
  logic [TimeW-1:0]  pub_period;

  // Tracking state kept between samples. The saved position stays zero until
  // the line is first seen, so it doubles as the remembered position.
  logic signed [PosW-1:0] saved_position;
  logic [TimeW-1:0]       lost_counter;
  logic [MaxChannels-1:0] previous_active_mask;
  logic [TimeW-1:0]       publish_counter;
  logic [TimeW-1:0]       last_publish_time;
  logic                   published_once;
  logic [TimeW-1:0]       now_ms;

  state_t state, state_next;

  logic                   accept;
  logic                   skip;
  logic [TimeW-1:0]       elapsed;
  logic [CountW-1:0]      n_used;
  logic                   scan_start;
  logic                   scan_done;
  scan_res_t              scan_res;
  logic                   div_start;
  logic                   div_done;
  logic signed [PosW-1:0] div_quot;
  logic                   publish;
  logic                   detected;

  // Output register fields.
  logic [MaxChannels-1:0] o_raw;
  logic [MaxChannels-1:0] o_act;
  logic [CountW-1:0]      o_cnt;
  logic                   o_det;
  logic signed [PosW-1:0] o_pos;
  logic signed [PosW-1:0] o_wpos;
  logic [1:0]             o_side;
  logic [TimeW-1:0]       o_lost;
  logic signed [PosW-1:0] o_mem;
  logic [MaxChannels-1:0] o_changed;
  logic [TimeW-1:0]       o_seq;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;

  // Elapsed time wraps modulo 2^32; the first tick after reset always passes.
  assign elapsed = s_tdata[InW-1:MaxChannels] - last_publish_time;
  assign skip    = published_once && (pub_period != '0) &&
                   (elapsed < pub_period);

  // Out-of-range channel counts are clamped to 1..MaxChannels.
  always_comb begin
    if (chan_num == '0) begin
      n_used = CountW'(1);
    end else if (chan_num > CountW'(MaxChannels)) begin
      n_used = CountW'(MaxChannels);
    end else begin
      n_used = chan_num;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_num   <= CountW'(MaxChannels);
      low_true   <= 1'b0;
      pub_period <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CHAN_NUM: chan_num   <= cfg_data[CountW-1:0];
        REG_LOW_TRUE: low_true   <= cfg_data[0];
        REG_PUBLISH:  pub_period <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && !skip) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) state_next = (scan_res.cnt != '0) ? ST_DIV : ST_PUBLISH;
      end
      ST_DIV: begin
        if (div_done) state_next = ST_PUBLISH;
      end
      ST_PUBLISH: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    scan_start = 1'b0;
    div_start  = 1'b0;
    publish    = 1'b0;
    unique case (state)
      ST_IDLE:    scan_start = accept && !skip;
      ST_SCAN:    div_start  = scan_done && (scan_res.cnt != '0);
      ST_DIV:     ;
      ST_PUBLISH: publish    = !m_tvalid || m_tready;
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_start) begin
      now_ms <= s_tdata[InW-1:MaxChannels];
    end
  end

  lspt_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .start    (scan_start),
    .levels   (s_tdata[MaxChannels-1:0]),
    .n_last   (ChanW'(n_used - 1'b1)),
    .low_true (low_true),
    .done     (scan_done),
    .res      (scan_res)
  );

  lspt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sum   (scan_res.sum),
    .cnt   (scan_res.cnt),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign detected = (scan_res.cnt != '0);

  // Sample commit: tracking state moves on in the same cycle the sample is
  // loaded into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      saved_position       <= '0;
      lost_counter         <= '0;
      previous_active_mask <= '0;
      publish_counter      <= '0;
      last_publish_time    <= '0;
      published_once       <= 1'b0;
    end else if (publish) begin
      if (detected) begin
        saved_position <= div_quot;
        lost_counter   <= '0;
      end else begin
        lost_counter   <= lost_counter + 1'b1;
      end
      previous_active_mask <= scan_res.act;
      publish_counter      <= publish_counter + 1'b1;
      last_publish_time    <= now_ms;
      published_once       <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (publish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (publish) begin
      o_raw     <= scan_res.raw;
      o_act     <= scan_res.act;
      o_cnt     <= scan_res.cnt;
      o_det     <= detected;
      o_changed <= scan_res.act ^ previous_active_mask;
      o_seq     <= publish_counter;
      if (detected) begin
        o_pos  <= div_quot;
        o_wpos <= div_quot;
        o_mem  <= div_quot;
        o_side <= SIDE_UNKNOWN;
        o_lost <= '0;
      end else begin
        o_pos  <= saved_position;
        o_wpos <= '0;
        o_mem  <= saved_position;
        o_lost <= lost_counter + 1'b1;
        if (saved_position < 0) begin
          o_side <= SIDE_LEFT;
        end else if (saved_position > 0) begin
          o_side <= SIDE_RIGHT;
        end else begin
          o_side <= SIDE_UNKNOWN;
        end
      end
    end
  end

  assign m_tdata = {1'b0, o_seq, o_changed, o_mem, o_lost, o_side,
                    o_wpos, o_pos, o_det, o_cnt, o_act, o_raw};

  // The scanner and divider only report back in the state that waits on them.
  a_scan_done_in_scan : assert property (@(posedge clk) disable iff (rst)
    scan_done |-> state == ST_SCAN)
    else $error("scanner finished outside the scan phase");

  a_div_done_in_div : assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_seq_steps : assert property (@(posedge clk) disable iff (rst)
    publish |=> publish_counter == $past(publish_counter) + 1'b1)
    else $error("sequence counter did not advance on a published sample");

  a_detect_matches_count : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (o_det == (o_cnt != '0)) && (o_det || o_wpos == '0))
    else $error("detection flag disagrees with the active count");

endmodule

// ===== hw/rtl/lspt_scan.sv =====
// ----------------------------------------------------------------------------
// lspt_scan: serial channel scanner
// Walks the channels one per cycle, building the raw and active masks, the
// active count and the sum of the active channels' centre offsets.
// ----------------------------------------------------------------------------
module lspt_scan (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [lspt_pkg::MaxChannels-1:0]     levels,
  input  logic [lspt_pkg::ChanW-1:0]           n_last,
  input  logic                                 low_true,
  output logic                                 done,
  output lspt_pkg::scan_res_t                  res
);
  import lspt_pkg::*;

  logic                   busy;
  logic [ChanW-1:0]       idx;
  logic [MaxChannels-1:0] lv;
  logic [ChanW-1:0]       last;
  logic                   pol;
  logic                   high;
  logic                   on;
  logic signed [SumW-1:0] digit;

  assign high  = lv[0];
  assign on    = high ^ pol;
  // Offset of channel idx from the centre, in half channel pitches.
  assign digit = $signed({2'b00, idx, 1'b0}) - $signed({3'b000, last});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && idx == last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx     <= '0;
      lv      <= levels;
      last    <= n_last;
      pol     <= low_true;
      res.raw <= '0;
      res.act <= '0;
      res.cnt <= '0;
      res.sum <= '0;
    end else if (busy) begin
      idx     <= idx + 1'b1;
      lv      <= lv >> 1;
      res.raw <= res.raw | (MaxChannels'(high) << idx);
      res.act <= res.act | (MaxChannels'(on) << idx);
      res.cnt <= res.cnt + CountW'(on);
      res.sum <= res.sum + (on ? digit : '0);
    end
  end

endmodule

// ===== hw/rtl/lspt_div.sv =====
// ----------------------------------------------------------------------------
// lspt_div: bit-serial mean divider
// Scales the offset sum to position units and divides it by the active
// count, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module lspt_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [lspt_pkg::SumW-1:0]     sum,
  input  logic [lspt_pkg::CountW-1:0]          cnt,
  output logic                                 done,
  output logic signed [lspt_pkg::PosW-1:0]     quot
);
  import lspt_pkg::*;

  logic              busy;
  logic [IterW-1:0]  iter;
  logic [MagW-1:0]   dq;
  logic [CountW-1:0] rem;
  logic [CountW-1:0] dvs;
  logic              neg;
  logic [SumW-1:0]   sum_abs;
  logic [CountW:0]   trial;
  logic              fits;
  logic [PosW-1:0]   q_ext;

  assign sum_abs = sum[SumW-1] ? SumW'(-sum) : SumW'(sum);
  assign trial   = {rem, dq[MagW-1]};
  assign fits    = trial >= {1'b0, dvs};
  assign q_ext   = PosW'(dq);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && iter == IterW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq   <= MagW'(sum_abs * HalfScale);
      rem  <= '0;
      dvs  <= cnt;
      neg  <= sum[SumW-1];
      iter <= IterW'(MagW);
    end else if (busy) begin
      iter <= iter - 1'b1;
      rem  <= fits ? CountW'(trial - {1'b0, dvs}) : trial[CountW-1:0];
      dq   <= {dq[MagW-2:0], fits};
    end
  end

  assign quot = neg ? $signed(-q_ext) : $signed(q_ext);

endmodule
